/* rtl/ryc_pkg.sv */
// Shared types, fixed-point constants and coefficient table for the color converter.
package ryc_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS = 14;
    localparam int PIX_W     = 8;
    localparam int OPND_W    = PIX_W + 1;
    localparam int COEF_W    = FRAC_BITS + 2;
    localparam int PROD_W    = OPND_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;

    localparam longint FX_ONE  = longint'(1) <<< FRAC_BITS;
    localparam longint FX_HALF = longint'(1) <<< (FRAC_BITS - 1);
    localparam longint FX_MID  = longint'(128) <<< FRAC_BITS;

    // Inverse constants, BT.601 (rounded to nearest)
    localparam longint INV_CR_R = ((longint'(1402) <<< FRAC_BITS) * 2 + 1000) / 2000;
    localparam longint INV_CB_G =
        ((longint'(344136) <<< FRAC_BITS) * 2 + 1000000) / 2000000;
    localparam longint INV_CR_G =
        ((longint'(714136) <<< FRAC_BITS) * 2 + 1000000) / 2000000;
    localparam longint INV_CB_B = ((longint'(1772) <<< FRAC_BITS) * 2 + 1000) / 2000;

    // Forward weights, BT.601 and BT.709
    localparam longint KR_601  = ((longint'(2990) <<< FRAC_BITS) * 2 + 10000) / 20000;
    localparam longint KB_601  = ((longint'(1140) <<< FRAC_BITS) * 2 + 10000) / 20000;
    localparam longint KR_709  = ((longint'(2126) <<< FRAC_BITS) * 2 + 10000) / 20000;
    localparam longint KB_709  = ((longint'(722) <<< FRAC_BITS) * 2 + 10000) / 20000;
    localparam longint CBR_601 = ((longint'(2990) <<< FRAC_BITS) * 2 + 17720) / 35440;
    localparam longint CBR_709 = ((longint'(2126) <<< FRAC_BITS) * 2 + 18556) / 37112;
    localparam longint CRB_601 = ((longint'(1140) <<< FRAC_BITS) * 2 + 14020) / 28040;
    localparam longint CRB_709 = ((longint'(722) <<< FRAC_BITS) * 2 + 15748) / 31496;

    // Rounding bias for luma and for chroma centered on 128
    localparam longint BIAS_Y = FX_HALF;
    localparam longint BIAS_C = FX_MID + FX_HALF;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DIRECTION     = 3'd0,
        CFG_MATRIX_SELECT = 3'd1,
        CFG_LUMA_OFFSET   = 3'd2,
        CFG_CHROMA_OFFSET = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             direction;
        logic             matrix_select;
        logic [PIX_W-1:0] luma_offset;
        logic [PIX_W-1:0] chroma_offset;
    } t_cfg;

    // Channel words
    typedef struct packed {
        logic [PIX_W-1:0] in_c0;
        logic [PIX_W-1:0] in_c1;
        logic [PIX_W-1:0] in_c2;
        logic             row_even;
        logic             col_even;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic             chroma_valid;
    } t_out;

    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // 3x3 matrix, entry [3*row + col]
    typedef logic [8:0][COEF_W-1:0] t_coef_mat;

    // Stage words
    typedef struct packed {
        logic  dir;
        logic  mtx;
        logic  cvld;
        t_opnd x0;
        t_opnd x1;
        t_opnd x2;
    } t_s1;

    typedef struct packed {
        logic  dir;
        logic  cvld;
        t_prod p00;
        t_prod p01;
        t_prod p02;
        t_prod p10;
        t_prod p11;
        t_prod p12;
        t_prod p20;
        t_prod p21;
        t_prod p22;
    } t_s2;

    typedef struct packed {
        logic cvld;
        t_acc a0;
        t_acc a1;
        t_acc a2;
    } t_s3;

    // Coefficient matrix for the selected direction and standard
    function automatic t_coef_mat coef_mat(input logic dir, input logic mtx);
        t_coef_mat m;
        longint    kr;
        longint    kb;
        longint    cbr;
        longint    crb;
        kr  = mtx ? KR_709  : KR_601;
        kb  = mtx ? KB_709  : KB_601;
        cbr = mtx ? CBR_709 : CBR_601;
        crb = mtx ? CRB_709 : CRB_601;
        if (!dir) begin
            m[0] = COEF_W'(FX_ONE);
            m[1] = COEF_W'(0);
            m[2] = COEF_W'(INV_CR_R);
            m[3] = COEF_W'(FX_ONE);
            m[4] = COEF_W'(-INV_CB_G);
            m[5] = COEF_W'(-INV_CR_G);
            m[6] = COEF_W'(FX_ONE);
            m[7] = COEF_W'(INV_CB_B);
            m[8] = COEF_W'(0);
        end else begin
            m[0] = COEF_W'(kr);
            m[1] = COEF_W'(FX_ONE - kr - kb);
            m[2] = COEF_W'(kb);
            m[3] = COEF_W'(-cbr);
            m[4] = COEF_W'(cbr - FX_HALF);
            m[5] = COEF_W'(FX_HALF);
            m[6] = COEF_W'(FX_HALF);
            m[7] = COEF_W'(crb - FX_HALF);
            m[8] = COEF_W'(-crb);
        end
        return m;
    endfunction

endpackage

/* rtl/rgb_ycbcr_color_convert.sv */
// Top level of the pixel color converter (YCbCr to RGB and RGB to YCbCr).
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one pixel word (three 8-bit
//   components plus row/column parity). Output channel: o_out_valid /
//   i_out_stall carry one converted word with the chroma_valid flag.
//   A word moves at a clock edge where valid is high and stall is low.
//   Configuration: i_cfg_valid / o_cfg_ready with register index and data;
//   write only while no pixel is in flight.
// Pipeline: prepare, multiply, sum and clamp/output register, each a registered
//   stage between input acceptance and the result on o_out_valid.
// Throughput: one pixel per clock while the receiver does not stall; each stage
//   holds one word.
// Reset: synchronous, active low; empties the pipeline and loads direction 0,
//   BT.601, luma offset 16 and chroma offset 128.
// Stall: when the receiver stalls, the output word holds and the pipeline
//   compacts into any empty stages; o_in_stall rises only once every stage
//   is full.
module rgb_ycbcr_color_convert (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ryc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ryc_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);

    ryc_pkg::t_cfg cfg;
    ryc_pkg::t_s1  s1_data;
    ryc_pkg::t_s2  s2_data;
    ryc_pkg::t_s3  s3_data;
    logic          s1_vld;
    logic          s2_vld;
    logic          s3_vld;
    logic          adv1;
    logic          adv2;
    logic          adv3;
    logic          adv4;

    // Advance a stage when it is empty or the next one advances
    assign adv4       = !o_out_valid || !i_out_stall;
    assign adv3       = !s3_vld || adv4;
    assign adv2       = !s2_vld || adv3;
    assign adv1       = !s1_vld || adv2;
    assign o_in_stall = !adv1;

    ryc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ryc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv1),
        .i_vld   (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .o_vld   (s1_vld),
        .o_data  (s1_data)
    );

    ryc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv2),
        .i_vld   (s1_vld),
        .i_data  (s1_data),
        .o_vld   (s2_vld),
        .o_data  (s2_data)
    );

    ryc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv3),
        .i_vld   (s2_vld),
        .i_data  (s2_data),
        .o_vld   (s3_vld),
        .o_data  (s3_data)
    );

    ryc_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv4),
        .i_vld   (s3_vld),
        .i_data  (s3_data),
        .o_vld   (o_out_valid),
        .o_data  (o_out_data)
    );

    // A full pipeline behind a stalled output must push back on the input
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && s1_vld && s2_vld && s3_vld) |-> o_in_stall)
        else $error("pipeline full and stalled but input not stalled");

    // An accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> s1_vld)
        else $error("accepted word missing from first stage");

    // A bubble moving into the output register leaves it empty
    a_bubble_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv4 && !s3_vld) |=> !o_out_valid)
        else $error("output valid without a word behind it");

endmodule

/* rtl/ryc_cfg.sv */
// Configuration registers of the color converter.
module ryc_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    output ryc_pkg::t_cfg         o_cfg
);

    ryc_pkg::t_cfg r_cfg;

    // Always take writes; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= 1'b0;
            r_cfg.matrix_select <= 1'b0;
            r_cfg.luma_offset   <= 8'd16;
            r_cfg.chroma_offset <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ryc_pkg::CFG_DIRECTION:     r_cfg.direction     <= i_cfg_data[0];
                ryc_pkg::CFG_MATRIX_SELECT: r_cfg.matrix_select <= i_cfg_data[0];
                ryc_pkg::CFG_LUMA_OFFSET:   r_cfg.luma_offset   <= i_cfg_data;
                ryc_pkg::CFG_CHROMA_OFFSET: r_cfg.chroma_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/ryc_prep.sv */
// Stage 1: operand preparation (offset removal) and chroma flag.
module ryc_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  ryc_pkg::t_in  i_data,
    input  ryc_pkg::t_cfg i_cfg,
    output logic          o_vld,
    output ryc_pkg::t_s1  o_data
);

    logic         r_vld;
    ryc_pkg::t_s1 r_data;
    ryc_pkg::t_s1 n_data;

    // Subtract offsets for YCbCr input, pass RGB through as positive values
    always_comb begin
        n_data.dir  = i_cfg.direction;
        n_data.mtx  = i_cfg.matrix_select;
        n_data.cvld = i_cfg.direction ? (i_data.row_even & i_data.col_even) : 1'b1;
        if (i_cfg.direction) begin
            n_data.x0 = $signed({1'b0, i_data.in_c0});
            n_data.x1 = $signed({1'b0, i_data.in_c1});
            n_data.x2 = $signed({1'b0, i_data.in_c2});
        end else begin
            n_data.x0 = $signed({1'b0, i_data.in_c0}) - $signed({1'b0, i_cfg.luma_offset});
            n_data.x1 = $signed({1'b0, i_data.in_c1})
                      - $signed({1'b0, i_cfg.chroma_offset});
            n_data.x2 = $signed({1'b0, i_data.in_c2})
                      - $signed({1'b0, i_cfg.chroma_offset});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* rtl/ryc_mult.sv */
// Stage 2: nine coefficient products of the 3x3 matrix.
module ryc_mult (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  ryc_pkg::t_s1 i_data,
    output logic         o_vld,
    output ryc_pkg::t_s2 o_data
);

    logic              r_vld;
    ryc_pkg::t_s2      r_data;
    ryc_pkg::t_s2      n_data;
    ryc_pkg::t_coef_mat coef;

    // Pick the matrix for the word's own mode and multiply
    always_comb begin
        coef        = ryc_pkg::coef_mat(i_data.dir, i_data.mtx);
        n_data.dir  = i_data.dir;
        n_data.cvld = i_data.cvld;
        n_data.p00  = i_data.x0 * ryc_pkg::t_coef'(coef[0]);
        n_data.p01  = i_data.x1 * ryc_pkg::t_coef'(coef[1]);
        n_data.p02  = i_data.x2 * ryc_pkg::t_coef'(coef[2]);
        n_data.p10  = i_data.x0 * ryc_pkg::t_coef'(coef[3]);
        n_data.p11  = i_data.x1 * ryc_pkg::t_coef'(coef[4]);
        n_data.p12  = i_data.x2 * ryc_pkg::t_coef'(coef[5]);
        n_data.p20  = i_data.x0 * ryc_pkg::t_coef'(coef[6]);
        n_data.p21  = i_data.x1 * ryc_pkg::t_coef'(coef[7]);
        n_data.p22  = i_data.x2 * ryc_pkg::t_coef'(coef[8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* rtl/ryc_sum.sv */
// Stage 3: row sums of the products plus rounding and chroma bias.
module ryc_sum (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  ryc_pkg::t_s2 i_data,
    output logic         o_vld,
    output ryc_pkg::t_s3 o_data
);

    logic          r_vld;
    ryc_pkg::t_s3  r_data;
    ryc_pkg::t_s3  n_data;
    ryc_pkg::t_acc bias_y;
    ryc_pkg::t_acc bias_c;

    // Chroma of RGB input is centered on 128; every row gets half an LSB
    always_comb begin
        bias_y = ryc_pkg::t_acc'(ryc_pkg::BIAS_Y);
        bias_c = i_data.dir ? ryc_pkg::t_acc'(ryc_pkg::BIAS_C)
                            : ryc_pkg::t_acc'(ryc_pkg::BIAS_Y);
        n_data.cvld = i_data.cvld;
        n_data.a0   = ryc_pkg::t_acc'(i_data.p00) + ryc_pkg::t_acc'(i_data.p01)
                    + ryc_pkg::t_acc'(i_data.p02) + bias_y;
        n_data.a1   = ryc_pkg::t_acc'(i_data.p10) + ryc_pkg::t_acc'(i_data.p11)
                    + ryc_pkg::t_acc'(i_data.p12) + bias_c;
        n_data.a2   = ryc_pkg::t_acc'(i_data.p20) + ryc_pkg::t_acc'(i_data.p21)
                    + ryc_pkg::t_acc'(i_data.p22) + bias_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* rtl/ryc_sat.sv */
// Stage 4: drop fraction bits, clamp to 0..255, output register.
module ryc_sat (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  ryc_pkg::t_s3  i_data,
    output logic          o_vld,
    output ryc_pkg::t_out o_data
);

    logic          r_vld;
    ryc_pkg::t_out r_data;
    ryc_pkg::t_out n_data;

    // Floor of the biased sum, limited to the pixel range
    function automatic logic [ryc_pkg::PIX_W-1:0] clamp(input ryc_pkg::t_acc acc);
        logic [ryc_pkg::PIX_W-1:0] res;
        if (acc[ryc_pkg::ACC_W-1]) begin
            res = '0;
        end else if (|acc[ryc_pkg::ACC_W-2:ryc_pkg::FRAC_BITS+ryc_pkg::PIX_W]) begin
            res = '1;
        end else begin
            res = acc[ryc_pkg::FRAC_BITS+ryc_pkg::PIX_W-1:ryc_pkg::FRAC_BITS];
        end
        return res;
    endfunction

    always_comb begin
        n_data.out_c0       = clamp(i_data.a0);
        n_data.out_c1       = clamp(i_data.a1);
        n_data.out_c2       = clamp(i_data.a2);
        n_data.chroma_valid = i_data.cvld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* bench/tb_rgb_ycbcr_color_convert.sv */
// Testbench for the RGB / YCbCr pixel converter: directed and random pixels with a local predictor.
`timescale 1ns / 1ps

module tb_rgb_ycbcr_color_convert;

    localparam int         PIPE_LATENCY   = 4;
    localparam int         FX_FRAC        = ryc_pkg::FRAC_BITS;
    localparam longint     FX_UNIT        = longint'(1) <<< FX_FRAC;
    localparam longint     FX_ROUND       = longint'(1) <<< (FX_FRAC - 1);
    localparam logic [2:0] CFG_IDX_UNUSED = 3'd6;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    ryc_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    ryc_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index;
    logic [7:0]    i_cfg_data;

    // Local copy of the converter registers
    logic       cfg_dir;
    logic       cfg_mtx;
    logic [7:0] cfg_luma;
    logic [7:0] cfg_chroma;

    ryc_pkg::t_out pending_px[$];
    int            mismatch_count;
    bit            idle_on;
    int            stall_left;
    ryc_pkg::t_out want;

    rgb_ycbcr_color_convert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Coefficient c = num/den scaled by 2^FX_FRAC, rounded to nearest
    function automatic longint fx_ratio(input longint num, input longint den);
        return ((num <<< FX_FRAC) * 2 + den) / (2 * den);
    endfunction

    // Round half up, then clamp to a byte
    function automatic logic [7:0] round_to_byte(input longint acc);
        longint q;
        acc = acc + FX_ROUND;
        if (acc < 0) begin
            return 8'd0;
        end
        q = acc >>> FX_FRAC;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Expected output word for one pixel under the current registers
    function automatic ryc_pkg::t_out convert_pixel(input ryc_pkg::t_in px);
        ryc_pkg::t_out res;
        longint a, b, c;
        longint y, u, v;
        longint kr, kb, kg, cb_r, cr_b, mid;
        a = longint'(px.in_c0);
        b = longint'(px.in_c1);
        c = longint'(px.in_c2);
        if (!cfg_dir) begin
            // YCbCr to RGB, always the BT.601 inverse
            y = (a - longint'(cfg_luma)) * FX_UNIT;
            u = b - longint'(cfg_chroma);
            v = c - longint'(cfg_chroma);
            res.out_c0       = round_to_byte(y + fx_ratio(1402, 1000) * v);
            res.out_c1       = round_to_byte(y - fx_ratio(344136, 1000000) * u
                                             - fx_ratio(714136, 1000000) * v);
            res.out_c2       = round_to_byte(y + fx_ratio(1772, 1000) * u);
            res.chroma_valid = 1'b1;
        end else begin
            // RGB to YCbCr, weights per matrix
            kr   = cfg_mtx ? fx_ratio(2126, 10000) : fx_ratio(2990, 10000);
            kb   = cfg_mtx ? fx_ratio(722, 10000)  : fx_ratio(1140, 10000);
            cb_r = cfg_mtx ? fx_ratio(2126, 18556) : fx_ratio(2990, 17720);
            cr_b = cfg_mtx ? fx_ratio(722, 15748)  : fx_ratio(1140, 14020);
            kg   = FX_UNIT - kr - kb;
            mid  = longint'(128) * FX_UNIT;
            res.out_c0 = round_to_byte(kr * a + kg * b + kb * c);
            res.out_c1 = round_to_byte(-cb_r * a + (cb_r - FX_ROUND) * b
                                       + FX_ROUND * c + mid);
            res.out_c2 = round_to_byte(FX_ROUND * a + (cr_b - FX_ROUND) * b
                                       - cr_b * c + mid);
            res.chroma_valid = px.row_even & px.col_even;
        end
        return res;
    endfunction

    // Check each delivered word and drive receiver stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_px.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word: c0=%0d c1=%0d c2=%0d cv=%0b",
                             o_out_data.out_c0, o_out_data.out_c1,
                             o_out_data.out_c2, o_out_data.chroma_valid);
                end
            end else begin
                want = pending_px.pop_front();
                if (o_out_data.out_c0 !== want.out_c0 || o_out_data.out_c1 !== want.out_c1 ||
                    o_out_data.out_c2 !== want.out_c2 ||
                    o_out_data.chroma_valid !== want.chroma_valid) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                 want.out_c0, want.out_c1, want.out_c2, want.chroma_valid,
                                 o_out_data.out_c0, o_out_data.out_c1,
                                 o_out_data.out_c2, o_out_data.chroma_valid);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one pixel, hold it until accepted, record its expected word
    task automatic send_pixel(input ryc_pkg::t_in px);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        pending_px.push_back(convert_pixel(px));
    endtask

    task automatic send_rgb(input logic [7:0] c0, c1, c2, input logic re, ce);
        ryc_pkg::t_in px;
        px.in_c0    = c0;
        px.in_c1    = c1;
        px.in_c2    = c2;
        px.row_even = re;
        px.col_even = ce;
        send_pixel(px);
    endtask

    // Drop valid, wait for every expected word, then let the pipe empty
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Write all registers, plus one write to an unused index that must be dropped
    task automatic apply_config(input logic dir, input logic mtx,
                                input logic [7:0] luma, input logic [7:0] chroma);
        logic [2:0] idx;
        logic [7:0] val;
        settle_pipeline();
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin
                    idx = ryc_pkg::CFG_DIRECTION;
                    val = {7'($urandom), dir};
                end
                1: begin
                    idx = CFG_IDX_UNUSED;
                    val = 8'($urandom);
                end
                2: begin
                    idx = ryc_pkg::CFG_MATRIX_SELECT;
                    val = {7'($urandom), mtx};
                end
                3: begin
                    idx = ryc_pkg::CFG_LUMA_OFFSET;
                    val = luma;
                end
                default: begin
                    idx = ryc_pkg::CFG_CHROMA_OFFSET;
                    val = chroma;
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                ryc_pkg::CFG_DIRECTION:     cfg_dir    = val[0];
                ryc_pkg::CFG_MATRIX_SELECT: cfg_mtx    = val[0];
                ryc_pkg::CFG_LUMA_OFFSET:   cfg_luma   = val;
                ryc_pkg::CFG_CHROMA_OFFSET: cfg_chroma = val;
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Reset register values: YCbCr to RGB, offsets 16 and 128
    task automatic test_reset_defaults();
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        send_rgb(8'd16, 8'd128, 8'd128, 1'b0, 1'b1);
        send_rgb(8'd235, 8'd128, 8'd128, 1'b1, 1'b0);
        send_rgb(8'd255, 8'd0, 8'd255, 1'b0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
    endtask

    // Offset extremes; matrix select must not matter here
    task automatic test_inverse_offsets();
        apply_config(1'b0, 1'b1, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        send_rgb(8'd128, 8'd0, 8'd255, 1'b0, 1'b1);
        apply_config(1'b0, 1'b0, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_rgb(8'd200, 8'd255, 8'd0, 1'b1, 1'b1);
    endtask

    // Forward conversion: black, white, grey, primaries, every position flag pair
    task automatic test_forward(input logic mtx);
        apply_config(1'b1, mtx, 8'($urandom), 8'($urandom));
        send_rgb(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        send_rgb(8'd77, 8'd77, 8'd77, 1'b1, 1'b0);
        send_rgb(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    endtask

    // Random pixels under a series of settings; the last phase runs without idling
    task automatic test_random_stream();
        logic [7:0] luma;
        logic [7:0] chroma;
        for (int phase = 0; phase < 6; phase++) begin
            luma   = (phase == 0) ? 8'd0 : (phase == 2) ? 8'd255 : 8'($urandom);
            chroma = (phase == 0) ? 8'd255 : (phase == 2) ? 8'd0 : 8'($urandom);
            if (phase == 5) begin
                idle_on = 1'b0;
            end
            apply_config(phase[0], phase[1] ^ phase[2], luma, chroma);
            for (int n = 0; n < 100; n++) begin
                send_rgb(8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        stall_left     = 0;
        idle_on        = 1'b0;
        cfg_dir        = 1'b0;
        cfg_mtx        = 1'b0;
        cfg_luma       = 8'd16;
        cfg_chroma     = 8'd128;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ryc_pkg::CFG_DIRECTION;
        i_cfg_data  <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        test_reset_defaults();
        test_inverse_offsets();
        test_forward(1'b0);
        test_forward(1'b1);
        test_random_stream();

        settle_pipeline();
        if (mismatch_count == 0 && pending_px.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ryc_pkg.sv
rtl/ryc_cfg.sv
rtl/ryc_prep.sv
rtl/ryc_mult.sv
rtl/ryc_sum.sv
rtl/ryc_sat.sv
rtl/rgb_ycbcr_color_convert.sv
bench/tb_rgb_ycbcr_color_convert.sv
